// File: src/lsh_pkg.sv
// Package for the LRU stack hit counter: item structs, config codes and sizes.
// It depends on nothing. Every other file in src imports it.
package lsh_pkg;

    localparam int DEF_STACK_DEPTH = 1024;
    localparam int DEF_ADDR_BITS   = 48;

    localparam int CAP_W   = 11;
    localparam int CNT_W   = 48;
    localparam int BADDR_W = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAP_SMALL  = 2'd0,
        CFG_CAP_MEDIUM = 2'd1,
        CFG_CAP_LARGE  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [BADDR_W-1:0] block_addr;
        logic               is_write;
    } in_item_t;

    typedef struct packed {
        logic             hit_small;
        logic             hit_medium;
        logic             hit_large;
        logic [CNT_W-1:0] read_hits_small;
        logic [CNT_W-1:0] write_hits_small;
        logic [CNT_W-1:0] read_hits_medium;
        logic [CNT_W-1:0] write_hits_medium;
        logic [CNT_W-1:0] read_hits_large;
        logic [CNT_W-1:0] write_hits_large;
        logic [CNT_W-1:0] read_blocks;
        logic [CNT_W-1:0] write_blocks;
    } out_item_t;

    // Control that travels with an item from cell to cell.
    typedef struct packed {
        logic       valid;
        logic       is_write;
        logic       found;
        logic       carry_valid;
        logic [2:0] hit;
    } wave_ctl_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

// File: src/lsh_cell.sv
// One recency stack cell: holds one address and passes the access wave on.
// Depends on lsh_pkg.
module lsh_cell #(
    parameter int CELL_IDX = 0,
    parameter int ADDR_W   = 48
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic [lsh_pkg::CAP_W-1:0] cap_small,
    input  logic [lsh_pkg::CAP_W-1:0] cap_medium,
    input  logic [lsh_pkg::CAP_W-1:0] cap_large,
    input  lsh_pkg::wave_ctl_t       ctl_in,
    input  logic [ADDR_W-1:0]        addr_in,
    input  logic [ADDR_W-1:0]        carry_in,
    output lsh_pkg::wave_ctl_t       ctl_out,
    output logic [ADDR_W-1:0]        addr_out,
    output logic [ADDR_W-1:0]        carry_out
);
    import lsh_pkg::*;

    localparam int CMP_W = ((CELL_IDX + 1) > 2048) ? 32 : 13;
    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(CELL_IDX);

    logic              slot_valid_reg;
    logic [ADDR_W-1:0] slot_reg;
    wave_ctl_t         ctl_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] carry_reg;

    logic              match;
    logic [2:0]        hit_here;
    wave_ctl_t         ctl_next;
    logic [ADDR_W-1:0] carry_next;

    function automatic logic below_cap(input logic [CAP_W-1:0] c,
                                       input logic [CMP_W-1:0] idx);
        logic [CMP_W-1:0] ce;
        ce = (c == '0) ? CMP_W'(1) : CMP_W'(c);
        below_cap = idx < ce;
    endfunction

    assign match = ctl_in.valid && !ctl_in.found && slot_valid_reg && (slot_reg == addr_in);
    assign hit_here = {below_cap(cap_large, MY_IDX), below_cap(cap_medium, MY_IDX),
                       below_cap(cap_small, MY_IDX)};

    always_comb
    begin
        ctl_next   = ctl_in;
        carry_next = slot_reg;
        if (match)
        begin
            ctl_next.found       = 1'b1;
            ctl_next.carry_valid = 1'b0;
            ctl_next.hit         = hit_here;
        end
        else if (!ctl_in.found)
        begin
            ctl_next.carry_valid = slot_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            ctl_reg        <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_next;
            // Once the address is found further down cells keep their contents.
            if (ctl_in.valid && !ctl_in.found)
            begin
                slot_valid_reg <= ctl_in.carry_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            addr_reg  <= addr_in;
            carry_reg <= carry_next;
            if (ctl_in.valid && !ctl_in.found)
            begin
                slot_reg <= carry_in;
            end
        end
    end

    assign ctl_out   = ctl_reg;
    assign addr_out  = addr_reg;
    assign carry_out = carry_reg;

endmodule

// File: src/lsh_counters.sv
// Tail of the chain: saturating hit and access counters and the result register.
// Depends on lsh_pkg.
module lsh_counters (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  lsh_pkg::wave_ctl_t ctl_in,
    output logic               out_valid,
    output lsh_pkg::out_item_t out_item
);
    import lsh_pkg::*;

    logic             out_valid_reg;
    logic [2:0]       hit_reg;
    logic [CNT_W-1:0] hits_reg [6];
    logic [CNT_W-1:0] totals_reg [2];
    logic             take;

    assign take = adv && ctl_in.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hit_reg       <= '0;
            for (int k = 0; k < 6; k++)
            begin
                hits_reg[k] <= '0;
            end
            totals_reg[0] <= '0;
            totals_reg[1] <= '0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= ctl_in.valid;
            end
            if (take)
            begin
                hit_reg <= ctl_in.hit;
                totals_reg[ctl_in.is_write] <= sat_inc(totals_reg[ctl_in.is_write]);
                for (int k = 0; k < 3; k++)
                begin
                    if (ctl_in.hit[k])
                    begin
                        hits_reg[2*k + int'(ctl_in.is_write)] <=
                            sat_inc(hits_reg[2*k + int'(ctl_in.is_write)]);
                    end
                end
            end
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        out_item.hit_small         = hit_reg[0];
        out_item.hit_medium        = hit_reg[1];
        out_item.hit_large         = hit_reg[2];
        out_item.read_hits_small   = hits_reg[0];
        out_item.write_hits_small  = hits_reg[1];
        out_item.read_hits_medium  = hits_reg[2];
        out_item.write_hits_medium = hits_reg[3];
        out_item.read_hits_large   = hits_reg[4];
        out_item.write_hits_large  = hits_reg[5];
        out_item.read_blocks       = totals_reg[0];
        out_item.write_blocks      = totals_reg[1];
    end

endmodule

// File: src/lru_stack_hit_counter_core.sv
// LRU recency stack hit counter: a chain of STACK_DEPTH cells plus counters.
// An item passes through the register of every cell in turn, then the result register.
// Throughput: one item per cycle; the whole chain stalls while a result waits.
// Reset clears all cell valid bits, the wave and all counters; capacities go to 1024.
// Depends on lsh_pkg, lsh_cell and lsh_counters.
module lru_stack_hit_counter_core #(
    parameter int STACK_DEPTH = lsh_pkg::DEF_STACK_DEPTH,
    parameter int ADDR_BITS   = lsh_pkg::DEF_ADDR_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  lsh_pkg::in_item_t            in_item,
    output logic                         out_valid,
    input  logic                         out_stall,
    output lsh_pkg::out_item_t           out_item,
    input  logic                         cfg_we,
    input  logic [lsh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lsh_pkg::CAP_W-1:0]    cfg_data
);
    import lsh_pkg::*;

    logic [CAP_W-1:0] cap_small_reg;
    logic [CAP_W-1:0] cap_medium_reg;
    logic [CAP_W-1:0] cap_large_reg;
    logic             adv;

    wave_ctl_t            ctl   [STACK_DEPTH+1];
    logic [ADDR_BITS-1:0] addr  [STACK_DEPTH+1];
    logic [ADDR_BITS-1:0] carry [STACK_DEPTH+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_small_reg  <= CAP_RESET;
            cap_medium_reg <= CAP_RESET;
            cap_large_reg  <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAP_SMALL:  cap_small_reg  <= cfg_data;
                CFG_CAP_MEDIUM: cap_medium_reg <= cfg_data;
                CFG_CAP_LARGE:  cap_large_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    assign ctl[0] = '{valid: in_valid, is_write: in_item.is_write, found: 1'b0,
                      carry_valid: 1'b1, hit: 3'b000};
    // The top cell always receives the accessed address as its new content.
    assign addr[0]  = ADDR_BITS'(in_item.block_addr);
    assign carry[0] = ADDR_BITS'(in_item.block_addr);

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        lsh_cell #(
            .CELL_IDX (i),
            .ADDR_W   (ADDR_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .cap_small  (cap_small_reg),
            .cap_medium (cap_medium_reg),
            .cap_large  (cap_large_reg),
            .ctl_in     (ctl[i]),
            .addr_in    (addr[i]),
            .carry_in   (carry[i]),
            .ctl_out    (ctl[i+1]),
            .addr_out   (addr[i+1]),
            .carry_out  (carry[i+1])
        );
    end

    lsh_counters u_counters (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .ctl_in    (ctl[STACK_DEPTH]),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    // The carry leaving the bottom cell holds the dropped LRU entry.
    logic [ADDR_BITS-1:0] unused_tail;
    assign unused_tail = addr[STACK_DEPTH] ^ carry[STACK_DEPTH];

    a_read_hits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.read_hits_small <= out_item.read_blocks)
        else $error("small cache read hits exceed read blocks");

    a_totals_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.write_blocks >= $past(out_item.write_blocks))
        else $error("write block total decreased");

    a_counts_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_item.read_blocks))
        else $error("read total changed while result stalled");

endmodule

// File: sim/tb_lru_stack_hit_counter_core.sv
// Testbench for lru_stack_hit_counter_core: predicts the LRU stack hit flags and
// counters of every item and compares them with the results of the block.
// Depends on lsh_pkg and the RTL of the core; it reads no file.
module tb_lru_stack_hit_counter_core;
    import lsh_pkg::*;

    localparam int DEPTH = DEF_STACK_DEPTH;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
    localparam int IDLE_LIMIT = 20000;

    class lru_scoreboard;
        logic [BADDR_W-1:0] recency[DEPTH];
        int                 occupancy;
        logic [CAP_W-1:0]   capacity[3];
        logic [CNT_W-1:0]   hit_count[6];
        logic [CNT_W-1:0]   block_count[2];
        out_item_t          expected_results[$];
        int                 errors;

        function new();
            occupancy = 0;
            errors = 0;
            foreach (capacity[k]) capacity[k] = CAP_RESET;
            foreach (hit_count[k]) hit_count[k] = '0;
            foreach (block_count[k]) block_count[k] = '0;
        endfunction

        function void set_capacity(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] value);
            if (idx < 3)
                capacity[idx] = value;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
            return (v == CNT_MAX) ? v : v + 1'b1;
        endfunction

        function void note_access(in_item_t item);
            int        pos;
            int        limit;
            int        keep;
            int        wr;
            bit        found;
            bit [2:0]  hit;
            out_item_t res;
            found = 0;
            pos = 0;
            wr = item.is_write;
            for (int i = 0; i < occupancy; i++)
                if (!found && recency[i] == item.block_addr)
                begin
                    found = 1;
                    pos = i;
                end
            block_count[wr] = bump(block_count[wr]);
            for (int k = 0; k < 3; k++)
            begin
                // A capacity of zero behaves as one, anything past the stack as full depth.
                limit = (capacity[k] == 0) ? 1 : (capacity[k] > DEPTH) ? DEPTH : capacity[k];
                hit[k] = found && (pos < limit);
                if (hit[k])
                    hit_count[2*k + wr] = bump(hit_count[2*k + wr]);
            end
            if (found)
                keep = pos;
            else if (occupancy < DEPTH)
            begin
                keep = occupancy;
                occupancy++;
            end
            else
                keep = DEPTH - 1;
            for (int i = keep; i > 0; i--)
                recency[i] = recency[i-1];
            recency[0] = item.block_addr;
            res.hit_small = hit[0];
            res.hit_medium = hit[1];
            res.hit_large = hit[2];
            res.read_hits_small = hit_count[0];
            res.write_hits_small = hit_count[1];
            res.read_hits_medium = hit_count[2];
            res.write_hits_medium = hit_count[3];
            res.read_hits_large = hit_count[4];
            res.write_hits_large = hit_count[5];
            res.read_blocks = block_count[0];
            res.write_blocks = block_count[1];
            expected_results.push_back(res);
        endfunction

        function void compare(string name, logic [CNT_W-1:0] exp_v, logic [CNT_W-1:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(out_item_t act);
            out_item_t exp_r;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h", $time, act);
                return;
            end
            exp_r = expected_results.pop_front();
            compare("hit_small", exp_r.hit_small, act.hit_small);
            compare("hit_medium", exp_r.hit_medium, act.hit_medium);
            compare("hit_large", exp_r.hit_large, act.hit_large);
            compare("read_hits_small", exp_r.read_hits_small, act.read_hits_small);
            compare("write_hits_small", exp_r.write_hits_small, act.write_hits_small);
            compare("read_hits_medium", exp_r.read_hits_medium, act.read_hits_medium);
            compare("write_hits_medium", exp_r.write_hits_medium, act.write_hits_medium);
            compare("read_hits_large", exp_r.read_hits_large, act.read_hits_large);
            compare("write_hits_large", exp_r.write_hits_large, act.write_hits_large);
            compare("read_blocks", exp_r.read_blocks, act.read_blocks);
            compare("write_blocks", exp_r.write_blocks, act.write_blocks);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_item;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CAP_W-1:0]     cfg_data = '0;

    lru_scoreboard        lru_model = new();
    int                   stall_left = 0;
    bit                   recv_quiet = 0;
    int                   gap_level = 1;
    int                   idle_cycles = 0;
    logic [BADDR_W-1:0]   addr_pool[$];

    lru_stack_hit_counter_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver stalls: mostly short bursts, now and then a long one.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (rst_n && !recv_quiet && $urandom_range(0, 5) == 0)
                stall_left <= ($urandom_range(0, 12) == 0) ? $urandom_range(20, 80)
                                                          : $urandom_range(1, 3);
        end
    end

    // Outputs settle by the falling edge and hold until the next rising edge.
    always @(negedge clk)
    begin
        if (out_valid && !out_stall)
            lru_model.check_result(out_item);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("lru_stack_hit_counter_core test failed");
            $finish;
        end
    end

    function automatic logic [BADDR_W-1:0] random_addr();
        return BADDR_W'({$urandom, $urandom});
    endfunction

    task automatic send_access(logic [BADDR_W-1:0] addr, logic wr);
        int gap;
        gap = 0;
        if (gap_level > 0 && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            @(posedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(posedge clk);
        end
        @(posedge clk);
        in_valid <= 1'b1;
        in_item <= '{block_addr: addr, is_write: wr};
        do
            @(negedge clk);
        while (in_stall);
        lru_model.note_access(in_item);
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic wait_idle();
        @(posedge clk);
        in_valid <= 1'b0;
        while (lru_model.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        lru_model.set_capacity(idx, value);
    endtask

    task automatic random_phase(int count, int pool_size, int fresh_pct);
        addr_pool.delete();
        for (int i = 0; i < pool_size; i++)
            addr_pool.push_back(random_addr());
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < fresh_pct)
                send_access(random_addr(), 1'($urandom_range(0, 1)));
            else
                send_access(addr_pool[$urandom_range(0, pool_size - 1)],
                            1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        logic [BADDR_W-1:0] base;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes of the address, reads and writes, repeats at the top of the stack.
        recv_quiet = 1;
        gap_level = 0;
        send_access('0, 1'b0);
        send_access('1, 1'b1);
        send_access('0, 1'b1);
        send_access('1, 1'b0);
        send_access('1, 1'b1);
        send_access(48'h5555_5555_5555, 1'b0);
        send_access(48'hAAAA_AAAA_AAAA, 1'b1);
        send_access('0, 1'b0);
        send_access(48'h5555_5555_5555, 1'b1);
        recv_quiet = 0;
        gap_level = 1;
        send_access(48'h8000_0000_0001, 1'b0);
        send_access('1, 1'b0);
        wait_idle();

        // Zero capacity acts as one, oversize as full depth; index 3 is no register.
        set_capacity(CFG_CAP_SMALL, '0);
        set_capacity(CFG_CAP_MEDIUM, 11'd1);
        set_capacity(CFG_CAP_LARGE, 11'd2047);
        set_capacity(CFG_NO_REG, 11'd5);
        send_access('0, 1'b1);
        send_access('0, 1'b0);
        random_phase(150, 8, 10);
        wait_idle();

        set_capacity(CFG_CAP_SMALL, 11'd2);
        set_capacity(CFG_CAP_MEDIUM, 11'd8);
        set_capacity(CFG_CAP_LARGE, 11'd32);
        recv_quiet = 1;
        random_phase(100, 48, 10);
        recv_quiet = 0;
        random_phase(100, 48, 10);
        wait_idle();

        // Overflow the stack so that early addresses fall off the bottom.
        set_capacity(CFG_CAP_SMALL, 11'd4);
        set_capacity(CFG_CAP_MEDIUM, 11'd512);
        set_capacity(CFG_CAP_LARGE, 11'd1024);
        base = random_addr();
        gap_level = 0;
        for (int i = 0; i < DEPTH + 6; i++)
            send_access(base + i, i[0]);
        gap_level = 1;
        for (int i = 0; i < 10; i++)
            send_access(base + i, 1'b0);
        send_access(base + 12, 1'b1);
        random_phase(150, 600, 5);
        wait_idle();

        set_capacity(CFG_CAP_SMALL, 11'd2047);
        set_capacity(CFG_CAP_MEDIUM, 11'd1023);
        set_capacity(CFG_CAP_LARGE, 11'd1);
        random_phase(60, 24, 10);

        wait_idle();
        repeat (DEPTH + 20) @(posedge clk);
        if (lru_model.errors == 0 && lru_model.expected_results.size() == 0)
            $display("lru_stack_hit_counter_core test passed");
        else
            $display("lru_stack_hit_counter_core test failed");
        $finish;
    end
endmodule
